// ----- sv/gaps_pkg.sv -----
// ----------------------------------------------------------------------------
// gaps_pkg: shared types and constants for the grid path search block
// Payload structs, cost limits, cell marks and sequencer state codes.
// ----------------------------------------------------------------------------
package gaps_pkg;

    localparam int ROWS_DEF      = 8;
    localparam int COLS_DEF      = 8;
    localparam int GW            = 10;
    localparam int FW            = 11;
    localparam int KW            = 6;
    localparam int MAX_OUT       = 64;
    localparam int STRAIGHT_COST = 10;
    localparam int DIAG_COST     = 14;
    localparam int H_SCALE       = 100;

    localparam logic [GW-1:0] G_LIMIT = 10'd1023;
    localparam logic [FW-1:0] F_LIMIT = 11'd2047;

    localparam logic [1:0] MARK_NONE   = 2'd0;
    localparam logic [1:0] MARK_OPEN   = 2'd1;
    localparam logic [1:0] MARK_CLOSED = 2'd2;

    localparam int STW = 5;
    localparam logic [STW-1:0] ST_CLR    = 5'd0;
    localparam logic [STW-1:0] ST_IDLE   = 5'd1;
    localparam logic [STW-1:0] ST_NOPATH = 5'd2;
    localparam logic [STW-1:0] ST_MCLR   = 5'd3;
    localparam logic [STW-1:0] ST_INIT   = 5'd4;
    localparam logic [STW-1:0] ST_SEL0   = 5'd5;
    localparam logic [STW-1:0] ST_SRD    = 5'd6;
    localparam logic [STW-1:0] ST_SFR    = 5'd7;
    localparam logic [STW-1:0] ST_SCMP   = 5'd8;
    localparam logic [STW-1:0] ST_SHF    = 5'd9;
    localparam logic [STW-1:0] ST_SHRD   = 5'd10;
    localparam logic [STW-1:0] ST_SHWR   = 5'd11;
    localparam logic [STW-1:0] ST_CURG   = 5'd12;
    localparam logic [STW-1:0] ST_NB     = 5'd13;
    localparam logic [STW-1:0] ST_NB1    = 5'd14;
    localparam logic [STW-1:0] ST_NB2    = 5'd15;
    localparam logic [STW-1:0] ST_NB3    = 5'd16;
    localparam logic [STW-1:0] ST_NCOST  = 5'd17;
    localparam logic [STW-1:0] ST_HST    = 5'd18;
    localparam logic [STW-1:0] ST_HWT    = 5'd19;
    localparam logic [STW-1:0] ST_UPD    = 5'd20;
    localparam logic [STW-1:0] ST_NXT    = 5'd21;
    localparam logic [STW-1:0] ST_PRD    = 5'd22;
    localparam logic [STW-1:0] ST_PWT    = 5'd23;

    typedef struct packed {
        logic       action;
        logic [2:0] row_index;
        logic [2:0] col_index;
        logic       wall;
        logic [2:0] goal_row;
        logic [2:0] goal_col;
    } t_in_item;

    typedef struct packed {
        logic          found;
        logic [2:0]    step_row;
        logic [2:0]    step_col;
        logic [GW-1:0] step_cost;
        logic          last;
    } t_out_item;

    typedef struct packed {
        logic [STW-1:0] op;
        logic           accept;
    } t_cmd;

    typedef struct packed {
        logic in_search;
        logic in_off;
        logic same;
        logic cnt_zero;
        logic scan_last;
        logic sh_more;
        logic nb_skip;
        logic nb_diag;
        logic blocked;
        logic closed;
        logic no_upd;
        logic sq_busy;
        logic nb_last;
        logic hit;
        logic out_free;
        logic path_last;
        logic clr_last;
    } t_status;

endpackage

// ----- sv/gaps_isqrt.sv -----
// ----------------------------------------------------------------------------
// gaps_isqrt: iterative integer square root
// Restoring method, one result bit per cycle, floor of the root.
// ----------------------------------------------------------------------------
module gaps_isqrt #(
    parameter int VW = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [VW-1:0]        i_value,
    output logic                 o_busy,
    output logic [(VW+1)/2-1:0]  o_root
);
    localparam int RTW = (VW + 1) / 2;
    localparam int PW  = 2 * RTW;
    localparam int CW  = $clog2(RTW + 1);

    logic [PW-1:0]  r_x;
    logic [RTW:0]   r_rem;
    logic [RTW-1:0] r_root;
    logic [CW-1:0]  r_cnt;
    logic [RTW+2:0] w_rem_sh;
    logic [RTW+2:0] w_trial;
    logic [RTW+2:0] w_diff;
    logic           w_ge;

    assign w_rem_sh = {r_rem, r_x[PW-1:PW-2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;
    assign o_busy   = (r_cnt != '0);
    assign o_root   = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(RTW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= PW'(i_value);
            r_rem  <= '0;
            r_root <= '0;
        end else if (o_busy) begin
            r_x    <= {r_x[PW-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[RTW:0] : w_rem_sh[RTW:0];
            r_root <= {r_root[RTW-2:0], w_ge};
        end
    end
endmodule

// ----- sv/gaps_dp.sv -----
// ----------------------------------------------------------------------------
// gaps_dp: search datapath
// Cell stores, open list, neighbor addressing, cost arithmetic, result register.
// ----------------------------------------------------------------------------
module gaps_dp #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gaps_pkg::t_cmd      i_cmd,
    input  gaps_pkg::t_in_item  i_in,
    input  logic                i_out_stall,
    output gaps_pkg::t_status   o_st,
    output logic                o_out_valid,
    output gaps_pkg::t_out_item o_out
);
    import gaps_pkg::*;

    localparam int RW   = $clog2(ROWS);
    localparam int CLW  = $clog2(COLS);
    localparam int IDW  = RW + CLW;
    localparam int NID  = 1 << IDW;
    localparam int CNTW = $clog2(NID + 1);
    localparam int MW   = (RW > CLW) ? RW : CLW;
    localparam int SQW  = 2 * MW + 1;
    localparam int VW   = SQW + 7;
    localparam int RTW  = (VW + 1) / 2;
    localparam int SUMW = ((RTW > GW) ? RTW : GW) + 1;
    localparam int NLIM = ROWS * COLS;

    logic           m_obs  [NID];
    logic [1:0]     m_mark [NID];
    logic [GW-1:0]  m_g    [NID];
    logic [FW-1:0]  m_f    [NID];
    logic [IDW-1:0] m_par  [NID];
    logic [IDW-1:0] m_ord  [NID];

    logic           r_obs_q;
    logic [1:0]     r_mark_q;
    logic [GW-1:0]  r_g_q;
    logic [FW-1:0]  r_f_q;
    logic [IDW-1:0] r_par_q;
    logic [IDW-1:0] r_ord_q;

    logic [IDW-1:0]  r_clr;
    logic [2:0]      r_sraw, r_scraw, r_graw, r_gcraw;
    logic [CNTW-1:0] r_cnt, r_idx, r_bi;
    logic [FW:0]     r_bf;
    logic [IDW-1:0]  r_bcell, r_cur, r_p;
    logic [GW-1:0]   r_cur_g, r_ng;
    logic [1:0]      r_di, r_dj;
    logic [SQW-1:0]  r_sq;
    logic            r_hit;
    logic [KW-1:0]   r_k;
    logic            r_ovalid;
    t_out_item       r_out;

    logic           obs_we, obs_wd, obs_re;
    logic [IDW-1:0] obs_wa, obs_ra;
    logic           mark_we, mark_re;
    logic [1:0]     mark_wd;
    logic [IDW-1:0] mark_wa, mark_ra;
    logic           g_we, g_re;
    logic [GW-1:0]  g_wd;
    logic [IDW-1:0] g_wa, g_ra;
    logic           f_we, f_re;
    logic [FW-1:0]  f_wd;
    logic [IDW-1:0] f_wa;
    logic           par_we, par_re;
    logic [IDW-1:0] par_wd, par_wa;
    logic           ord_we, ord_re;
    logic [IDW-1:0] ord_wd, ord_wa, ord_ra;

    logic [IDW-1:0]  w_start, w_goal, w_in_id, w_n, w_ortho_a, w_ortho_b;
    logic [RW-1:0]   w_cr, w_nr, w_gr, w_dr;
    logic [CLW-1:0]  w_cc, w_nc, w_gc, w_dc;
    logic [RW:0]     w_nr_x;
    logic [CLW:0]    w_nc_x;
    logic [MW-1:0]   w_drm, w_dcm;
    logic [SQW-1:0]  w_sq;
    logic [GW:0]     w_ng_sum;
    logic [GW-1:0]   w_ng;
    logic [SUMW-1:0] w_f_sum;
    logic [FW-1:0]   w_f;
    logic [CNTW-1:0] w_idx1;
    logic            w_off, w_center, w_diag, w_wr_on, w_new;
    logic            w_out_free, w_ld_np, w_ld_path;
    logic            w_sq_start, w_sq_busy;
    logic [VW-1:0]   w_hval;
    logic [RTW-1:0]  w_root;

    assign w_start = {RW'(r_sraw), CLW'(r_scraw)};
    assign w_gr    = RW'(r_graw);
    assign w_gc    = CLW'(r_gcraw);
    assign w_goal  = {w_gr, w_gc};
    assign w_in_id = {RW'(i_in.row_index), CLW'(i_in.col_index)};
    assign w_cr    = r_cur[IDW-1:CLW];
    assign w_cc    = r_cur[CLW-1:0];
    assign w_nr_x  = {1'b0, w_cr} + (RW+1)'(r_di) - (RW+1)'(1);
    assign w_nc_x  = {1'b0, w_cc} + (CLW+1)'(r_dj) - (CLW+1)'(1);
    assign w_nr    = w_nr_x[RW-1:0];
    assign w_nc    = w_nc_x[CLW-1:0];
    assign w_n       = {w_nr, w_nc};
    assign w_ortho_a = {w_cr, w_nc};
    assign w_ortho_b = {w_nr, w_cc};
    assign w_off = (r_di == 2'd0 && w_cr == '0) || (r_di == 2'd2 && w_cr == RW'(ROWS - 1))
                || (r_dj == 2'd0 && w_cc == '0) || (r_dj == 2'd2 && w_cc == CLW'(COLS - 1));
    assign w_center = (r_di == 2'd1) && (r_dj == 2'd1);
    assign w_diag   = (r_di != 2'd1) && (r_dj != 2'd1);
    assign w_new    = (r_mark_q == MARK_NONE);
    assign w_wr_on  = (int'(i_in.row_index) < ROWS) && (int'(i_in.col_index) < COLS);
    assign w_idx1   = r_idx + CNTW'(1);

    assign w_ng_sum = {1'b0, r_cur_g} + (w_diag ? (GW+1)'(DIAG_COST) : (GW+1)'(STRAIGHT_COST));
    assign w_ng     = (w_ng_sum > {1'b0, G_LIMIT}) ? G_LIMIT : w_ng_sum[GW-1:0];

    assign w_dr  = (w_nr >= w_gr) ? (w_nr - w_gr) : (w_gr - w_nr);
    assign w_dc  = (w_nc >= w_gc) ? (w_nc - w_gc) : (w_gc - w_nc);
    assign w_drm = MW'(w_dr);
    assign w_dcm = MW'(w_dc);
    assign w_sq  = SQW'(w_drm) * SQW'(w_drm) + SQW'(w_dcm) * SQW'(w_dcm);

    assign w_hval     = VW'(r_sq) * VW'(H_SCALE);
    assign w_sq_start = (i_cmd.op == ST_HST);
    assign w_f_sum    = SUMW'(r_ng) + SUMW'(w_root);
    assign w_f        = (w_f_sum > SUMW'(F_LIMIT)) ? F_LIMIT : w_f_sum[FW-1:0];

    gaps_isqrt #(.VW(VW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (w_hval),
        .o_busy  (w_sq_busy),
        .o_root  (w_root)
    );

    always_comb begin
        obs_we = 1'b0;  obs_wa = w_in_id;  obs_wd = i_in.wall;  obs_re = 1'b0;  obs_ra = w_n;
        mark_we = 1'b0; mark_wa = w_n;     mark_wd = MARK_OPEN; mark_re = 1'b0; mark_ra = w_n;
        g_we = 1'b0;    g_wa = w_n;        g_wd = r_ng;         g_re = 1'b0;    g_ra = w_n;
        f_we = 1'b0;    f_wa = w_n;        f_wd = w_f;          f_re = 1'b0;
        par_we = 1'b0;  par_wa = w_n;      par_wd = r_cur;      par_re = 1'b0;
        ord_we = 1'b0;  ord_wa = r_idx[IDW-1:0]; ord_wd = r_ord_q;
        ord_re = 1'b0;  ord_ra = r_idx[IDW-1:0];
        case (i_cmd.op)
            ST_CLR: begin
                obs_we = 1'b1; obs_wa = r_clr; obs_wd = 1'b0;
            end
            ST_IDLE: begin
                obs_we = i_cmd.accept && !i_in.action && w_wr_on;
            end
            ST_MCLR: begin
                mark_we = 1'b1; mark_wa = r_clr; mark_wd = MARK_NONE;
            end
            ST_INIT: begin
                mark_we = 1'b1; mark_wa = w_start;
                g_we    = 1'b1; g_wa    = w_start; g_wd = '0;
                f_we    = 1'b1; f_wa    = w_start; f_wd = '0;
                par_we  = 1'b1; par_wa  = w_start; par_wd = w_start;
                ord_we  = 1'b1; ord_wa  = '0;      ord_wd = w_start;
            end
            ST_SRD: begin
                ord_re = 1'b1;
            end
            ST_SFR: begin
                f_re = 1'b1;
            end
            ST_SHRD: begin
                if (w_idx1 < r_cnt) begin
                    ord_re = 1'b1; ord_ra = w_idx1[IDW-1:0];
                end else begin
                    mark_we = 1'b1; mark_wa = r_cur; mark_wd = MARK_CLOSED;
                    g_re    = 1'b1; g_ra    = r_cur;
                end
            end
            ST_SHWR: begin
                ord_we = 1'b1;
            end
            ST_NB: begin
                obs_re = 1'b1; mark_re = 1'b1; g_re = 1'b1;
            end
            ST_NB1: begin
                obs_re = 1'b1; obs_ra = w_ortho_a;
            end
            ST_NB2: begin
                obs_re = 1'b1; obs_ra = w_ortho_b;
            end
            ST_UPD: begin
                g_we    = 1'b1;
                f_we    = 1'b1;
                par_we  = 1'b1;
                mark_we = w_new;
                ord_we  = w_new; ord_wa = r_cnt[IDW-1:0]; ord_wd = w_n;
            end
            ST_PRD: begin
                g_re = 1'b1; g_ra = r_p; par_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (obs_we) m_obs[obs_wa] <= obs_wd;
        if (obs_re) r_obs_q <= m_obs[obs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) m_mark[mark_wa] <= mark_wd;
        if (mark_re) r_mark_q <= m_mark[mark_ra];
    end

    always_ff @(posedge i_clk) begin
        if (g_we) m_g[g_wa] <= g_wd;
        if (g_re) r_g_q <= m_g[g_ra];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) m_f[f_wa] <= f_wd;
        if (f_re) r_f_q <= m_f[r_ord_q];
    end

    always_ff @(posedge i_clk) begin
        if (par_we) m_par[par_wa] <= par_wd;
        if (par_re) r_par_q <= m_par[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) m_ord[ord_wa] <= ord_wd;
        if (ord_re) r_ord_q <= m_ord[ord_ra];
    end

    assign w_out_free = !r_ovalid || !i_out_stall;
    assign w_ld_np    = (i_cmd.op == ST_NOPATH) && w_out_free;
    assign w_ld_path  = (i_cmd.op == ST_PWT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == ST_CLR || i_cmd.op == ST_MCLR) begin
                r_clr <= r_clr + IDW'(1);
            end
            if (w_ld_np || w_ld_path) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_np) begin
            r_out <= '{found: 1'b0, step_row: r_graw, step_col: r_gcraw,
                       step_cost: '0, last: 1'b1};
        end else if (w_ld_path) begin
            r_out <= '{found: 1'b1, step_row: 3'(r_p[IDW-1:CLW]), step_col: 3'(r_p[CLW-1:0]),
                       step_cost: r_g_q, last: o_st.path_last};
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ST_IDLE: begin
                if (i_cmd.accept) begin
                    r_sraw  <= i_in.row_index;
                    r_scraw <= i_in.col_index;
                    r_graw  <= i_in.goal_row;
                    r_gcraw <= i_in.goal_col;
                end
            end
            ST_INIT: begin
                r_cnt <= CNTW'(1);
                r_hit <= 1'b0;
                r_p   <= w_goal;
                r_k   <= '0;
            end
            ST_SEL0: begin
                r_idx <= '0;
                r_bi  <= '0;
                r_bf  <= '1;
            end
            ST_SCMP: begin
                if ({1'b0, r_f_q} < r_bf) begin
                    r_bf    <= {1'b0, r_f_q};
                    r_bi    <= r_idx;
                    r_bcell <= r_ord_q;
                end
                r_idx <= w_idx1;
            end
            ST_SHF: begin
                r_idx <= r_bi;
                r_cur <= r_bcell;
            end
            ST_SHRD: begin
                if (!(w_idx1 < r_cnt)) r_cnt <= r_cnt - CNTW'(1);
            end
            ST_SHWR: begin
                r_idx <= w_idx1;
            end
            ST_CURG: begin
                r_cur_g <= r_g_q;
                r_di    <= 2'd0;
                r_dj    <= 2'd0;
            end
            ST_NCOST: begin
                r_ng <= w_ng;
                r_sq <= w_sq;
            end
            ST_UPD: begin
                if (w_new) begin
                    r_cnt <= r_cnt + CNTW'(1);
                    if (w_n == w_goal) r_hit <= 1'b1;
                end
            end
            ST_NXT: begin
                if (r_dj == 2'd2) begin
                    r_dj <= 2'd0;
                    r_di <= r_di + 2'd1;
                end else begin
                    r_dj <= r_dj + 2'd1;
                end
            end
            ST_PWT: begin
                if (w_out_free) begin
                    r_p <= r_par_q;
                    r_k <= r_k + KW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_st.in_search = i_in.action;
        o_st.in_off    = !(w_wr_on && (int'(i_in.goal_row) < ROWS)
                           && (int'(i_in.goal_col) < COLS));
        o_st.same      = (w_start == w_goal);
        o_st.cnt_zero  = (r_cnt == '0);
        o_st.scan_last = (w_idx1 == r_cnt);
        o_st.sh_more   = (w_idx1 < r_cnt);
        o_st.nb_skip   = w_off || w_center;
        o_st.nb_diag   = w_diag;
        o_st.blocked   = r_obs_q;
        o_st.closed    = (r_mark_q == MARK_CLOSED);
        o_st.no_upd    = (r_mark_q == MARK_OPEN) ? !(w_ng < r_g_q)
                                                 : (r_cnt >= CNTW'(NLIM));
        o_st.sq_busy   = w_sq_busy;
        o_st.nb_last   = (r_di == 2'd2) && (r_dj == 2'd2);
        o_st.hit       = r_hit;
        o_st.out_free  = w_out_free;
        o_st.path_last = (r_p == w_start) || (r_k == KW'(MAX_OUT - 1));
        o_st.clr_last  = &r_clr;
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
endmodule

// ----- sv/gaps_ctrl.sv -----
// ----------------------------------------------------------------------------
// gaps_ctrl: search sequencer
// Steps the clearing passes, open list scan, neighbor checks and path readout.
// ----------------------------------------------------------------------------
module gaps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  gaps_pkg::t_status i_st,
    output logic              o_in_stall,
    output gaps_pkg::t_cmd    o_cmd
);
    import gaps_pkg::*;

    logic [STW-1:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:    if (i_st.clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid && i_st.in_search) begin
                    n_state = i_st.in_off ? ST_NOPATH : ST_MCLR;
                end
            end
            ST_NOPATH: if (i_st.out_free) n_state = ST_IDLE;
            ST_MCLR:   if (i_st.clr_last) n_state = ST_INIT;
            ST_INIT:   n_state = i_st.same ? ST_PRD : ST_SEL0;
            ST_SEL0:   n_state = i_st.cnt_zero ? ST_NOPATH : ST_SRD;
            ST_SRD:    n_state = ST_SFR;
            ST_SFR:    n_state = ST_SCMP;
            ST_SCMP:   n_state = i_st.scan_last ? ST_SHF : ST_SRD;
            ST_SHF:    n_state = ST_SHRD;
            ST_SHRD:   n_state = i_st.sh_more ? ST_SHWR : ST_CURG;
            ST_SHWR:   n_state = ST_SHRD;
            ST_CURG:   n_state = ST_NB;
            ST_NB:     n_state = i_st.nb_skip ? ST_NXT : ST_NB1;
            ST_NB1: begin
                if (i_st.blocked || i_st.closed) n_state = ST_NXT;
                else n_state = i_st.nb_diag ? ST_NB2 : ST_NCOST;
            end
            ST_NB2:    n_state = i_st.blocked ? ST_NXT : ST_NB3;
            ST_NB3:    n_state = i_st.blocked ? ST_NXT : ST_NCOST;
            ST_NCOST:  n_state = i_st.no_upd ? ST_NXT : ST_HST;
            ST_HST:    n_state = ST_HWT;
            ST_HWT:    if (!i_st.sq_busy) n_state = ST_UPD;
            ST_UPD:    n_state = ST_NXT;
            ST_NXT: begin
                if (i_st.nb_last) n_state = i_st.hit ? ST_PRD : ST_SEL0;
                else n_state = ST_NB;
            end
            ST_PRD:    n_state = ST_PWT;
            ST_PWT: begin
                if (i_st.out_free) n_state = i_st.path_last ? ST_IDLE : ST_PRD;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_cmd.op     = r_state;
    assign o_cmd.accept = i_in_valid && (r_state == ST_IDLE);
endmodule

// ----- sv/grid_astar_path_search_top.sv -----
// ----------------------------------------------------------------------------
// grid_astar_path_search_top: 8-connected A* search on a cell grid
//
// channel | direction | handshake                    | payload
// in      | input     | i_in_valid / o_in_stall      | i_in  (write cell or search)
// out     | output    | o_out_valid / i_out_stall    | o_out (path cell, goal first)
//
// Reset runs a clearing pass over the cell map.
// A search first clears the marks, then for each expansion scans every open
// entry (order read, f read, compare), shifts the later entries down over the
// chosen one, and checks each neighbor: marks and walls, also the orthogonal
// walls of a diagonal step, then cost and the bit-serial heuristic root.
// Each path result is read from the stores and then loaded into the output
// register, which waits while the output stalls.
// ----------------------------------------------------------------------------
module grid_astar_path_search_top #(
    parameter int ROWS = gaps_pkg::ROWS_DEF,
    parameter int COLS = gaps_pkg::COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gaps_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gaps_pkg::t_out_item o_out
);
    import gaps_pkg::*;

    t_cmd    w_cmd;
    t_status w_st;
    logic    w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    gaps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (w_st),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    gaps_dp #(.ROWS(ROWS), .COLS(COLS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_st        (w_st),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_in.action |=> !$rose(o_out_valid))
        else $error("cell write produced a result");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in.action |=> o_in_stall)
        else $error("search transfer did not start the sequencer");

    a_nopath_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.found |-> o_out.last && (o_out.step_cost == '0))
        else $error("no-path result malformed");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (w_cmd.op == ST_IDLE) && w_cmd.accept)
        else $error("input transfer outside idle");
endmodule
